// File: hdl/bcpf_pkg.sv
`timescale 1ns / 1ps
package bcpf_pkg;

    localparam int DEF_MAX_BLOCK_BYTES = 16;

    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_PLAIN  = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    localparam logic [1:0] KIND_CIPHER = 2'd0;
    localparam logic [1:0] KIND_PLAIN  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] REG_ENCRYPT = 2'd0;
    localparam logic [1:0] REG_PADDING = 2'd1;
    localparam logic [1:0] REG_BSIZE   = 2'd2;

    localparam logic       RST_ENCRYPT = 1'b1;
    localparam logic       RST_PADDING = 1'b1;
    localparam logic [4:0] RST_BSIZE   = 5'd8;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       bend;
        logic       fin;
        logic       st;
        logic       last;
    } t_res;

endpackage

// File: hdl/bcpf_in_if.sv
`timescale 1ns / 1ps
interface bcpf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink (input valid, input operation, input data_byte, output ready);
endinterface

// File: hdl/bcpf_out_if.sv
`timescale 1ns / 1ps
interface bcpf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic       block_end;
    logic       final_block;
    logic       status;
    logic       last;

    modport source (output valid, output result_kind, output out_byte, output block_end,
                    output final_block, output status, output last, input ready);
    modport sink (input valid, input result_kind, input out_byte, input block_end,
                  input final_block, input status, input last, output ready);
endinterface

// File: hdl/bcpf_buf.sv
`timescale 1ns / 1ps
module bcpf_buf import bcpf_pkg::*; #(
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
    parameter int AW              = $clog2(MAX_BLOCK_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [MAX_BLOCK_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[i_raddr];

endmodule

// File: hdl/bcpf_ctrl.sv
`timescale 1ns / 1ps
module bcpf_ctrl import bcpf_pkg::*; #(
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
    parameter int AW              = $clog2(MAX_BLOCK_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [4:0]    i_cfg_data,
    bcpf_in_if.sink       i_in_ch,
    bcpf_out_if.source    o_out_ch,
    output logic          o_buf_we,
    output logic [AW-1:0] o_buf_waddr,
    output logic [7:0]    o_buf_wdata,
    output logic [AW-1:0] o_buf_raddr,
    input  logic [7:0]    i_buf_rdata
);

    localparam int CW = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int EW = (CW > 5) ? CW : 5;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEND  = 3'd1;
    localparam logic [2:0] S_CHK0  = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_PLAIN = 3'd4;
    localparam logic [2:0] S_STAT  = 3'd5;
    localparam logic [2:0] S_BYP   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic          r_enc, r_pad;
    logic [4:0]    r_bsz;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_await, n_await;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_fin, n_fin;
    logic          r_subst, n_subst;
    logic          r_stat_after, n_stat_after;
    logic          r_pend, n_pend;
    logic [7:0]    r_byte, n_byte;
    logic [CW-1:0] r_padv, n_padv;
    logic [7:0]    r_pval, n_pval;
    logic [CW-1:0] r_plen, n_plen;
    logic          r_st, n_st;
    logic          r_ov;
    t_res          r_res;

    logic [EW-1:0] bsz_x;
    logic [CW-1:0] bs;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] chk_addr;
    logic [CW-1:0] last_addr;
    logic          can_emit;
    logic          emit;
    t_res          res;
    logic          misorder;
    logic          bend;
    logic          ok0;
    logic          cfg_clr;

    always_comb begin
        bsz_x = EW'(r_bsz);
        if (bsz_x == '0) begin
            bs = CW'(1);
        end else if (bsz_x > EW'(MAX_BLOCK_BYTES)) begin
            bs = CW'(MAX_BLOCK_BYTES);
        end else begin
            bs = CW'(bsz_x);
        end
    end

    assign cnt_inc   = r_cnt + CW'(1);
    assign last_addr = bs - CW'(1);
    assign chk_addr  = last_addr - r_idx;
    assign can_emit  = !r_ov || o_out_ch.ready;
    assign misorder  = (i_in_ch.operation == OP_RSVD) ||
                       (r_await != (i_in_ch.operation == OP_PLAIN));
    assign cfg_clr   = i_cfg_we && (i_cfg_idx <= REG_BSIZE);
    assign i_in_ch.ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_await      = r_await;
        n_idx        = r_idx;
        n_fin        = r_fin;
        n_subst      = r_subst;
        n_stat_after = r_stat_after;
        n_pend       = r_pend;
        n_byte       = r_byte;
        n_padv       = r_padv;
        n_pval       = r_pval;
        n_plen       = r_plen;
        n_st         = r_st;
        o_buf_we     = 1'b0;
        o_buf_waddr  = r_cnt[AW-1:0];
        o_buf_wdata  = i_in_ch.data_byte;
        o_buf_raddr  = r_idx[AW-1:0];
        emit         = 1'b0;
        res          = '0;
        bend         = (r_idx == last_addr);
        ok0          = (i_buf_rdata != 8'd0) && (i_buf_rdata <= 8'(bs));
        unique case (r_state)
            S_IDLE: begin
                if (i_in_ch.valid) begin
                    if (misorder) begin
                        n_st    = ST_ERR;
                        n_state = S_STAT;
                    end else if (i_in_ch.operation == OP_PLAIN) begin
                        o_buf_we = 1'b1;
                        if (cnt_inc >= bs) begin
                            n_cnt   = '0;
                            n_await = 1'b0;
                            n_state = S_CHK0;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end else if (i_in_ch.operation == OP_DATA) begin
                        n_idx        = '0;
                        n_fin        = 1'b0;
                        n_subst      = 1'b0;
                        n_stat_after = 1'b0;
                        n_byte       = i_in_ch.data_byte;
                        if (bs == CW'(1)) begin
                            n_state = S_BYP;
                        end else if (r_cnt >= bs) begin
                            n_pend  = 1'b1;
                            n_state = S_SEND;
                        end else begin
                            o_buf_we = 1'b1;
                            n_pend   = 1'b0;
                            if (cnt_inc == bs && (r_enc || !r_pad)) begin
                                n_state = S_SEND;
                            end else begin
                                n_cnt = cnt_inc;
                            end
                        end
                    end else begin
                        n_idx  = '0;
                        n_pend = 1'b0;
                        if (bs == CW'(1)) begin
                            n_st    = ST_OK;
                            n_state = S_STAT;
                        end else if (r_enc) begin
                            if (r_pad) begin
                                n_padv       = bs - r_cnt;
                                n_subst      = 1'b1;
                                n_stat_after = 1'b1;
                                n_fin        = 1'b0;
                                n_state      = S_SEND;
                            end else begin
                                n_st    = (r_cnt != '0) ? ST_ERR : ST_OK;
                                n_state = S_STAT;
                            end
                        end else if (r_cnt == bs && r_pad) begin
                            n_fin        = 1'b1;
                            n_subst      = 1'b0;
                            n_stat_after = 1'b0;
                            n_await      = 1'b1;
                            n_state      = S_SEND;
                        end else if (r_cnt == '0 && !r_pad) begin
                            n_st    = ST_OK;
                            n_state = S_STAT;
                        end else begin
                            n_st    = ST_ERR;
                            n_state = S_STAT;
                        end
                    end
                end
            end
            S_SEND: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    res.kind  = KIND_CIPHER;
                    res.data  = (r_subst && r_idx >= r_cnt) ? 8'(r_padv) : i_buf_rdata;
                    res.bend  = bend;
                    res.fin   = r_fin;
                    res.last  = bend && !r_stat_after;
                    n_idx     = r_idx + CW'(1);
                    if (bend) begin
                        if (r_pend) begin
                            o_buf_we    = 1'b1;
                            o_buf_waddr = '0;
                            o_buf_wdata = r_byte;
                            n_cnt       = CW'(1);
                            n_pend      = 1'b0;
                        end else begin
                            n_cnt = '0;
                        end
                        if (r_stat_after) begin
                            n_st    = ST_OK;
                            n_state = S_STAT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_CHK0: begin
                o_buf_raddr = last_addr[AW-1:0];
                n_pval      = i_buf_rdata;
                n_plen      = bs - CW'(i_buf_rdata);
                n_idx       = '0;
                if (ok0) begin
                    n_state = S_CHK;
                end else begin
                    n_st    = ST_ERR;
                    n_state = S_STAT;
                end
            end
            S_CHK: begin
                o_buf_raddr = chk_addr[AW-1:0];
                if (i_buf_rdata != r_pval) begin
                    n_st    = ST_ERR;
                    n_state = S_STAT;
                end else if (8'(r_idx) == r_pval - 8'd1) begin
                    n_idx = '0;
                    if (r_plen == '0) begin
                        n_st    = ST_OK;
                        n_state = S_STAT;
                    end else begin
                        n_state = S_PLAIN;
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_PLAIN: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    res.kind = KIND_PLAIN;
                    res.data = i_buf_rdata;
                    n_idx    = r_idx + CW'(1);
                    if (r_idx == r_plen - CW'(1)) begin
                        n_st    = ST_OK;
                        n_state = S_STAT;
                    end
                end
            end
            S_STAT: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    res.kind = KIND_STATUS;
                    res.st   = r_st;
                    res.last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_BYP: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    res.kind = KIND_CIPHER;
                    res.data = r_byte;
                    res.bend = 1'b1;
                    res.last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_enc   <= RST_ENCRYPT;
            r_pad   <= RST_PADDING;
            r_bsz   <= RST_BSIZE;
            r_cnt   <= '0;
            r_await <= 1'b0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            // a write to the encrypt, padding or block size register restarts the stream
            if (cfg_clr) begin
                r_cnt   <= '0;
                r_await <= 1'b0;
            end else begin
                r_cnt   <= n_cnt;
                r_await <= n_await;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ENCRYPT: begin
                        r_enc <= i_cfg_data[0];
                    end
                    REG_PADDING: begin
                        r_pad <= i_cfg_data[0];
                    end
                    REG_BSIZE: begin
                        r_bsz <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_fin        <= n_fin;
        r_subst      <= n_subst;
        r_stat_after <= n_stat_after;
        r_byte       <= n_byte;
        r_padv       <= n_padv;
        r_pval       <= n_pval;
        r_plen       <= n_plen;
        r_st         <= n_st;
        if (emit) begin
            r_res <= res;
        end
    end

    assign o_out_ch.valid       = r_ov;
    assign o_out_ch.result_kind = r_res.kind;
    assign o_out_ch.out_byte    = r_res.data;
    assign o_out_ch.block_end   = r_res.bend;
    assign o_out_ch.final_block = r_res.fin;
    assign o_out_ch.status      = r_res.st;
    assign o_out_ch.last        = r_res.last;

endmodule

// File: hdl/block_cipher_padding_framer_unit.sv
`timescale 1ns / 1ps
// results leave one per cycle while the sink is ready, during a block send or a plaintext run
// a block send reads the buffer out in order; a padding check reads the last byte, then the pad bytes
// a byte that only fills the buffer is written into it; every item runs through one sequencer
// one item at a time: input ready is high only while the sequencer is idle
// reset: synchronous active low, registers return to encrypt, padding on, block size 8
module block_cipher_padding_framer_unit import bcpf_pkg::*; #(
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [4:0] i_cfg_data,
    bcpf_in_if.sink    i_in_ch,
    bcpf_out_if.source o_out_ch
);

    localparam int AW = $clog2(MAX_BLOCK_BYTES);

    logic          buf_we;
    logic [AW-1:0] buf_waddr;
    logic [7:0]    buf_wdata;
    logic [AW-1:0] buf_raddr;
    logic [7:0]    buf_rdata;

    bcpf_ctrl #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .AW              (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_ch     (i_in_ch),
        .o_out_ch    (o_out_ch),
        .o_buf_we    (buf_we),
        .o_buf_waddr (buf_waddr),
        .o_buf_wdata (buf_wdata),
        .o_buf_raddr (buf_raddr),
        .i_buf_rdata (buf_rdata)
    );

    bcpf_buf #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .AW              (AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

endmodule

// File: hdl/bcpf_checker.sv
`timescale 1ns / 1ps
module bcpf_checker import bcpf_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [7:0] i_out_byte,
    input logic       i_out_bend,
    input logic       i_out_fin,
    input logic       i_out_status,
    input logic       i_out_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) &&
                                        $stable(i_out_kind) && $stable(i_out_last))
        else $error("stalled transaction changed");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_STATUS |->
            i_out_byte == 8'd0 && !i_out_bend && !i_out_fin && i_out_last)
        else $error("status transaction carries data");

    a_plain_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_PLAIN |-> !i_out_bend && !i_out_fin && !i_out_status)
        else $error("plaintext transaction carries flags");

    a_ready_only_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_in_ready |-> i_out_last)
        else $error("input ready while item results remain");

endmodule

bind block_cipher_padding_framer_unit bcpf_checker u_bcpf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in_ch.ready),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_out_kind   (o_out_ch.result_kind),
    .i_out_byte   (o_out_ch.out_byte),
    .i_out_bend   (o_out_ch.block_end),
    .i_out_fin    (o_out_ch.final_block),
    .i_out_status (o_out_ch.status),
    .i_out_last   (o_out_ch.last)
);
